>>> rtl/north_referenced_azimuth_top_defines.svh
// Assertion macros for the north-referenced azimuth block.
`ifndef NORTH_REFERENCED_AZIMUTH_TOP_DEFINES_SVH
`define NORTH_REFERENCED_AZIMUTH_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define NRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/nra_pkg.sv
// Package: constants, arctangent table and stage type for the azimuth CORDIC.
`default_nettype none

package nra_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int ITERATIONS  = 16;

  // coordinates are scaled up by 2^PRE_SHIFT before the rotations
  localparam int PRE_SHIFT   = 24;
  // three guard bits cover negation and the CORDIC gain
  localparam int DATA_WIDTH  = COORD_WIDTH + PRE_SHIFT + 3;
  // internal angle: 2^TURN_WIDTH units per turn
  localparam int TURN_WIDTH  = 32;
  localparam int ROUND_SHIFT = TURN_WIDTH - ANGLE_WIDTH;

  localparam logic [TURN_WIDTH-1:0] HALF_TURN = {1'b1, {(TURN_WIDTH-1){1'b0}}};

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TURN_WIDTH-1:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] y;
    logic        [TURN_WIDTH-1:0] z;
    logic                         org;
  } stage_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH:0] azimuth;
    logic                        at_origin;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/north_referenced_azimuth_top.sv
// One beat per cycle while the skid register is empty; in_ready is low while it holds a beat.
// One pre-rotation stage, one register stage per CORDIC iteration, one output register.
// Rate is set by the single-step-per-stage CORDIC chain; a skid register keeps intake
// running for one beat while the output is stalled.
// Reset (rst, synchronous, active high) clears all valid bits and range_mode to 0.
`default_nettype none
`include "north_referenced_azimuth_top_defines.svh"

module north_referenced_azimuth_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [nra_pkg::COORD_WIDTH-1:0] north,
  input  logic signed [nra_pkg::COORD_WIDTH-1:0] east,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [nra_pkg::ANGLE_WIDTH:0]   azimuth,
  output logic                                   at_origin,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_data
);

  localparam int DW  = nra_pkg::DATA_WIDTH;
  localparam int CW  = nra_pkg::COORD_WIDTH;
  localparam int AW  = nra_pkg::ANGLE_WIDTH;
  localparam int TW  = nra_pkg::TURN_WIDTH;
  localparam int SH  = nra_pkg::ROUND_SHIFT;
  localparam int NIT = nra_pkg::ITERATIONS;

  // rounding half-step plus the one that completes the two's complement negation
  localparam logic [TW:0]   RND  = (TW+1)'(((64'd1 << SH) >> 1) + 64'd1);
  localparam logic [AW-1:0] HALF = {1'b1, {(AW-1){1'b0}}};

  logic range_mode;

  nra_pkg::stage_t st  [NIT+1];
  logic            vld [NIT+1];

  logic en;
  nra_pkg::result_t res_next;
  nra_pkg::result_t out_q;
  nra_pkg::result_t skid;
  logic             skid_valid;
  logic             arrive;

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign in_ready  = en;
  assign arrive    = en && vld[NIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode <= 1'b0;
    end else if (cfg_valid) begin
      range_mode <= cfg_data;
    end
  end

  // pre-rotation into the right half plane
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  assign xs = {{3{north[CW-1]}}, north, {nra_pkg::PRE_SHIFT{1'b0}}};
  assign ys = {{3{east[CW-1]}}, east, {nra_pkg::PRE_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].org <= (north == '0) && (east == '0);
      if (north[CW-1]) begin
        st[0].x <= -xs;
        st[0].y <= -ys;
        st[0].z <= nra_pkg::HALF_TURN;
      end else begin
        st[0].x <= xs;
        st[0].y <= ys;
        st[0].z <= '0;
      end
    end
  end

  // one vectoring step per stage
  for (genvar k = 0; k < NIT; k++) begin : g_iter
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    assign dx = st[k].y >>> k;
    assign dy = st[k].x >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].org <= st[k].org;
        if (!st[k].y[DW-1]) begin
          st[k+1].x <= st[k].x + dx;
          st[k+1].y <= st[k].y - dy;
          st[k+1].z <= st[k].z + nra_pkg::ATAN_TABLE[k];
        end else begin
          st[k+1].x <= st[k].x - dx;
          st[k+1].y <= st[k].y + dy;
          st[k+1].z <= st[k].z - nra_pkg::ATAN_TABLE[k];
        end
      end
    end
  end

  // negate, round half up to AW bits, fold into the selected range
  logic [TW:0]   zsum;
  logic [AW-1:0] az;
  assign zsum = {1'b0, ~st[NIT].z} + RND;
  assign az   = zsum[SH +: AW];

  always_comb begin
    res_next.at_origin = st[NIT].org;
    if (st[NIT].org) begin
      res_next.azimuth = '0;
    end else if (!range_mode && (az > HALF)) begin
      res_next.azimuth = {1'b1, az};
    end else begin
      res_next.azimuth = {1'b0, az};
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= arrive;
      end
    end else if (!out_valid) begin
      out_valid <= arrive;
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_q <= skid;
      end else begin
        out_q <= res_next;
      end
    end else if (!out_valid) begin
      out_q <= res_next;
    end else if (arrive) begin
      skid <= res_next;
    end
  end

  assign azimuth   = out_q.azimuth;
  assign at_origin = out_q.at_origin;

  `NRA_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid, "skid holds a beat while output is empty")
  `NRA_ASSERT_NEXT(a_skid_holds, skid_valid && !out_ready, skid_valid, "skid beat lost while stalled")
  `NRA_ASSERT_NOW(a_origin_zero, out_valid && at_origin, azimuth == '0, "origin beat with nonzero angle")
  `NRA_ASSERT_NOW(a_range1_pos, out_valid && range_mode, !azimuth[AW], "negative angle in 0..2pi range")

endmodule

`default_nettype wire

>>> sim/north_referenced_azimuth_top_tb.sv
// Self-checking testbench for the north-referenced azimuth CORDIC block.
`default_nettype none

module north_referenced_azimuth_top_tb;

  localparam int CW             = nra_pkg::COORD_WIDTH;
  localparam int AW             = nra_pkg::ANGLE_WIDTH;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 275;
  localparam int NUM_ROWS       = 13;
  localparam int HALF_ANGLE     = 1 << (AW - 1);

  localparam bit RANGE_SIGNED   = 1'b0;  // (-pi, pi]
  localparam bit RANGE_UNSIGNED = 1'b1;  // [0, 2pi)

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] north;
  logic signed [CW-1:0] east;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [AW:0]   azimuth;
  logic                 at_origin;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_data;

  north_referenced_azimuth_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .north     (north),
    .east      (east),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .azimuth   (azimuth),
    .at_origin (at_origin),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    int north;
    int east;
    bit typed;   // expected value below is used as is
    int az;
    bit org;
  } coord_row_t;

  // origin, north axis, south, the four corners, axis extremes and the
  // near-north pair that rounds up to a full turn
  coord_row_t coord_rows [NUM_ROWS] = '{
    '{0,      0,      1'b1, 0,          1'b1},
    '{32767,  0,      1'b1, 0,          1'b0},
    '{-32768, 0,      1'b1, HALF_ANGLE, 1'b0},
    '{-1,     0,      1'b1, HALF_ANGLE, 1'b0},
    '{0,      32767,  1'b0, 0,          1'b0},
    '{0,      -32768, 1'b0, 0,          1'b0},
    '{32767,  32767,  1'b0, 0,          1'b0},
    '{-32768, -32768, 1'b0, 0,          1'b0},
    '{-32768, 32767,  1'b0, 0,          1'b0},
    '{32767,  -32768, 1'b0, 0,          1'b0},
    '{32767,  1,      1'b0, 0,          1'b0},
    '{32767,  -1,     1'b0, 0,          1'b0},
    '{-32768, 1,      1'b0, 0,          1'b0}
  };

  nra_pkg::result_t pending_azimuths [$];
  nra_pkg::result_t head_azimuth;
  bit      range_setting;
  bit      steady;
  bit      hold_req;
  int      mismatches;
  int      results_checked;
  int      pairs_sent;
  int      origin_pairs;
  int      range_writes;
  int      idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bit-exact azimuth: half-turn pre-rotation, CORDIC vectoring, negate,
  // round half up, fold into the selected range.
  function automatic nra_pkg::result_t azimuth_of(logic signed [CW-1:0] n,
                                                  logic signed [CW-1:0] e,
                                                  bit mode);
    longint           x;
    longint           y;
    longint           dx;
    longint           dy;
    logic [31:0]      z;
    logic [32:0]      turn;
    logic [AW-1:0]    a;
    nra_pkg::result_t r;
    r.azimuth   = '0;
    r.at_origin = 1'b0;
    if (n == 0 && e == 0) begin
      r.at_origin = 1'b1;
      return r;
    end
    x = longint'(n) <<< nra_pkg::PRE_SHIFT;
    y = longint'(e) <<< nra_pkg::PRE_SHIFT;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = nra_pkg::HALF_TURN;
    end
    for (int i = 0; i < nra_pkg::ITERATIONS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + nra_pkg::ATAN_TABLE[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - nra_pkg::ATAN_TABLE[i];
      end
    end
    turn = {1'b0, 32'd0 - z} + (33'd1 << (nra_pkg::ROUND_SHIFT - 1));
    a = turn[nra_pkg::ROUND_SHIFT +: AW];
    r.azimuth = {1'b0, a};
    if (mode == RANGE_SIGNED && a > HALF_ANGLE)
      r.azimuth = {1'b1, a};
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    int r;
    int v;
    r = $urandom_range(15);
    case (r)
      6, 7: v = $urandom_range(8) - 4;
      8: begin
        case ($urandom_range(5))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 1;
          4: v = 32766;
          default: v = 32767;
        endcase
      end
      9: v = 0;
      10: begin
        v = 1 << $urandom_range(14);
        if ($urandom_range(1)) v = -v;
      end
      11, 12: v = $urandom_range(600) - 300;
      default: v = $urandom;
    endcase
    return CW'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_checked, got, want);
  endtask

  // One coordinate beat; the expected result is queued when it is taken.
  task automatic send_coord(logic signed [CW-1:0] n,
                            logic signed [CW-1:0] e,
                            nra_pkg::result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    north    <= n;
    east     <= e;
    do @(posedge clk); while (!in_ready);
    pending_azimuths.push_back(want);
    pairs_sent++;
    if (want.at_origin)
      origin_pairs++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_azimuths.size() != 0) @(posedge clk);
  endtask

  task automatic write_range(bit mode);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    range_setting = mode;
    range_writes++;
  endtask

  task automatic walk_coord_rows();
    nra_pkg::result_t want;
    for (int k = 0; k < NUM_ROWS; k++) begin
      if (coord_rows[k].typed) begin
        want.azimuth   = (AW+1)'(coord_rows[k].az);
        want.at_origin = coord_rows[k].org;
      end else begin
        want = azimuth_of(CW'(coord_rows[k].north), CW'(coord_rows[k].east),
                          range_setting);
      end
      send_coord(CW'(coord_rows[k].north), CW'(coord_rows[k].east), want);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int run_left;
    int hold_left;
    run_left  = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (run_left > 0) begin
        out_ready <= 1'b0;
        run_left--;
      end else begin
        run_left = pick_gap();
        if (run_left > 0) begin
          out_ready <= 1'b0;
          run_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_azimuths.size() == 0) begin
        report_mismatch("unexpected beat", azimuth, 0);
      end else begin
        head_azimuth = pending_azimuths.pop_front();
        if (azimuth !== head_azimuth.azimuth)
          report_mismatch("azimuth", azimuth, head_azimuth.azimuth);
        if (at_origin !== head_azimuth.at_origin)
          report_mismatch("at_origin", at_origin, head_azimuth.at_origin);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending_azimuths.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic signed [CW-1:0] n;
    logic signed [CW-1:0] e;
    rst           = 1'b1;
    in_valid      = 1'b0;
    north         = '0;
    east          = '0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    range_setting = RANGE_SIGNED;
    steady        = 1'b0;
    hold_req      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows: once with the reset range, once in the unsigned range
    walk_coord_rows();
    write_range(RANGE_UNSIGNED);
    walk_coord_rows();

    for (int p = 0; p < PHASES; p++) begin
      write_range(p[0] ? RANGE_UNSIGNED : RANGE_SIGNED);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        steady = (p == 2 || p == 5) && k < 120;
        if (p == 1 && k == 60)
          hold_req = 1'b1;
        if (p == 3 && k == 150)
          wait_drained();
        if ($urandom_range(39) == 0) begin
          n = '0;
          e = '0;
        end else begin
          n = pick_coord();
          e = pick_coord();
        end
        send_coord(n, e, azimuth_of(n, e, range_setting));
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_azimuths.size() != 0)
      report_mismatch("missing results", 0, pending_azimuths.size());

    $display("covered %0d coordinate pairs (%0d at the origin), %0d range writes",
             pairs_sent, origin_pairs, range_writes);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
